### src/rde_pkg.sv
// shared constants and types for the reversible deque engine
// operation codes, field widths and the result record
// no dependencies
package rde_pkg;

  // default number of store entries
  localparam int DEPTH_DEF = 64;

  // field widths
  localparam int FUNC_W  = 3;
  localparam int VALUE_W = 31;

  // operation codes carried in func
  localparam logic [FUNC_W-1:0] FN_CLEAR = 3'd0;
  localparam logic [FUNC_W-1:0] FN_PUSH  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_REV   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_DEL   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_EMIT  = 3'd4;

  // one result transaction
  typedef struct packed {
    logic               overflow;
    logic               empty_list;
    logic               error;
    logic               last;
    logic [VALUE_W-1:0] element;
  } result_t;

endpackage

### src/reversible_deque_engine.sv
// Reversible deque engine: a bounded deque held in a ring store with a
// reverse flag. Clear, push, reverse and delete are taken without stalling
// and give no result. Emit holds the input side while it runs: after a
// start step it makes one store read per cycle while the output buffer has
// room, through the single read port of the element memory, or gives just
// the lone error or empty result. Results leave through a two-entry
// output buffer, so the next operation is taken while results still
// wait; a stalled output slows emit down to the rate it is drained at.
// The store needs no clearing after reset.
// depends on rde_pkg
module reversible_deque_engine #(
  parameter int DEPTH = rde_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // func [2:0], value [33:3], zero fill
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // element [30:0], zero fill
  output logic        m_axis_tlast,
  output logic [2:0]  m_axis_tuser    // error [0], empty_list [1], overflow [2]
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [IW:0]   DEPTH_W  = (IW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  // ring index addition, both operands below DEPTH
  function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] a,
                                              input logic [IW-1:0] b);
    logic [IW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= DEPTH_W) begin
      s = s - DEPTH_W;
    end
    return s[IW-1:0];
  endfunction

  // deque state
  logic                       state;
  logic [IW-1:0]              head;
  logic [CW-1:0]              count;
  logic                       rev;
  logic                       err;
  logic                       ovf;

  // emit sequencer
  logic [IW-1:0]              em_addr;
  logic [CW-1:0]              em_rem;
  logic                       em_single;
  logic                       em_err;
  logic                       em_empty;

  // read stage
  logic                       rd_pend;
  logic                       rd_last;
  logic                       rd_err;
  logic                       rd_empty;
  logic                       rd_zero;
  logic                       rd_ovf;
  logic [rde_pkg::VALUE_W-1:0] mem_q;

  // output buffer
  rde_pkg::result_t           ob0;
  rde_pkg::result_t           ob1;
  logic [1:0]                 ocnt;

  logic [rde_pkg::VALUE_W-1:0] mem [DEPTH];

  logic [rde_pkg::FUNC_W-1:0]  func;
  logic [rde_pkg::VALUE_W-1:0] value;
  logic                        s_acc;
  logic                        pop;
  logic                        issue;
  logic [2:0]                  occ_after;
  logic                        push_ok;
  logic [IW-1:0]               wr_addr;
  logic [IW-1:0]               back_addr;
  rde_pkg::result_t            land;

  // input decode
  assign func  = s_axis_tdata[2:0];
  assign value = s_axis_tdata[33:3];

  assign s_axis_tready = (state == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  assign push_ok   = (count != DEPTH_C);
  assign wr_addr   = wrap_add(head, IW'(count));
  assign back_addr = wrap_add(head, IW'(count - CW'(1)));

  // buffer credit: buffered plus in flight minus leaving this cycle
  assign pop       = (ocnt != 2'd0) && m_axis_tready;
  assign occ_after = {1'b0, ocnt} + {2'b00, rd_pend} - {2'b00, pop};
  assign issue     = (state == ST_EMIT) && (occ_after < 3'd2);

  // control state and emit sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      head    <= '0;
      count   <= '0;
      rev     <= 1'b0;
      err     <= 1'b0;
      ovf     <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= issue;
      if (s_acc) begin
        unique case (func)
          rde_pkg::FN_CLEAR: begin
            head  <= '0;
            count <= '0;
            rev   <= 1'b0;
            err   <= 1'b0;
            ovf   <= 1'b0;
          end
          rde_pkg::FN_PUSH: begin
            if (push_ok) begin
              count <= count + CW'(1);
            end else begin
              ovf <= 1'b1;
            end
          end
          rde_pkg::FN_REV: begin
            rev <= !rev;
          end
          rde_pkg::FN_DEL: begin
            if (!err) begin
              if (count == '0) begin
                err <= 1'b1;
              end else begin
                if (!rev) begin
                  head <= (head == LAST_IDX) ? '0 : head + IW'(1);
                end
                count <= count - CW'(1);
              end
            end
          end
          rde_pkg::FN_EMIT: begin
            state <= ST_EMIT;
          end
          default: begin
          end
        endcase
      end else if (issue && (em_single || em_rem == CW'(1))) begin
        state <= ST_IDLE;
      end
    end
  end

  // emit sequencer registers
  always_ff @(posedge clk) begin
    if (s_acc && func == rde_pkg::FN_EMIT) begin
      em_single <= err || (count == '0);
      em_err    <= err;
      em_empty  <= !err && (count == '0);
      em_rem    <= count;
      em_addr   <= rev ? back_addr : head;
    end else if (issue) begin
      em_rem <= em_rem - CW'(1);
      if (rev) begin
        em_addr <= (em_addr == '0) ? LAST_IDX : em_addr - IW'(1);
      end else begin
        em_addr <= (em_addr == LAST_IDX) ? '0 : em_addr + IW'(1);
      end
    end
  end

  // read stage tags travel with the memory read
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_last  <= em_single || (em_rem == CW'(1));
      rd_err   <= em_err;
      rd_empty <= em_empty;
      rd_zero  <= em_single;
      rd_ovf   <= ovf;
    end
  end

  // element store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (s_acc && func == rde_pkg::FN_PUSH && push_ok) begin
      mem[wr_addr] <= value;
    end
    if (issue) begin
      mem_q <= mem[em_addr];
    end
  end

  // result landing from the read stage
  always_comb begin
    land.element    = rd_zero ? '0 : mem_q;
    land.last       = rd_last;
    land.error      = rd_err;
    land.empty_list = rd_empty;
    land.overflow   = rd_ovf;
  end

  // output buffer occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      ocnt <= 2'd0;
    end else begin
      unique case ({rd_pend, pop})
        2'b10:   ocnt <= ocnt + 2'd1;
        2'b01:   ocnt <= ocnt - 2'd1;
        default: ocnt <= ocnt;
      endcase
    end
  end

  // output buffer payload
  always_ff @(posedge clk) begin
    unique case (ocnt)
      2'd0: begin
        if (rd_pend) begin
          ob0 <= land;
        end
      end
      2'd1: begin
        if (rd_pend && pop) begin
          ob0 <= land;
        end else if (rd_pend) begin
          ob1 <= land;
        end
      end
      2'd2: begin
        if (pop) begin
          ob0 <= ob1;
          if (rd_pend) begin
            ob1 <= land;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // output ports
  assign m_axis_tvalid = (ocnt != 2'd0);
  assign m_axis_tdata  = {1'b0, ob0.element};
  assign m_axis_tlast  = ob0.last;
  assign m_axis_tuser  = {ob0.overflow, ob0.empty_list, ob0.error};

endmodule
